>>> src/dsum_pkg.sv
// Shared constants and types for the divisor sum core.
package dsum_pkg;

	localparam int SUM_BITS = 40;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_ADD_D = 5'b00100,
		ST_ADD_Q = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

endpackage

>>> src/dsum_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module dsum_divider #(
	parameter int W = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  div_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          fits;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[W-2:0], fits};
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

>>> src/divisor_sum_trial_division_core.sv
// Top level: sum of divisors by trial division over one shared divider.
//
// Input channel: n with in_valid / in_ready. Output channel: divisor_sum
// with out_valid / out_ready. One request gives exactly one result.
// in_ready is high only while the sequencer is idle; one request is
// worked on at a time.
// For each trial divisor d = 1, 2, ... the shared restoring divider
// computes n / d and n % d; a hit adds d and, unless n / d equals d,
// n / d as well. The run ends at the first d with d > n / d, so at most
// floor(sqrt(n)) + 1 divisions run per request. The divider is the only
// arithmetic loop and sets the run time.
// The result goes to an output register; a new request is taken while it
// waits. If the receiver stalls and a second result is ready, the
// sequencer holds in its final state until the register frees up.
// Reset (arst_n low) drops any request in progress and clears out_valid.
module divisor_sum_trial_division_core #(
	parameter int VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_BITS-1:0] n,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [39:0]           divisor_sum
);

	import dsum_pkg::*;

	localparam int W   = VALUE_BITS;
	localparam int EXT = (W > SUM_BITS) ? W : SUM_BITS;

	state_t                state_q;
	logic [W-1:0]          v_q;
	logic [W-1:0]          d_q;
	logic [SUM_BITS-1:0]   acc_q;
	logic [SUM_BITS-1:0]   out_q;
	logic                  out_valid_q;
	logic                  start_q;
	logic                  div_done;
	logic [W-1:0]          quot;
	logic [W-1:0]          rem;
	logic [EXT-1:0]        d_wide;
	logic [EXT-1:0]        q_wide;
	logic                  in_fire;
	logic                  out_free;

	dsum_divider #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (v_q),
		.divisor  (d_q),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	assign d_wide   = EXT'(d_q);
	assign q_wide   = EXT'(quot);
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= ((state_q == ST_FIN) && out_free) || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					start_q <= in_fire;
					if (in_fire) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					start_q <= div_done && !(d_q > quot) && (rem != '0);
					if (div_done) begin
						if (d_q > quot) begin
							state_q <= ST_FIN;
						end else if (rem == '0) begin
							state_q <= ST_ADD_D;
						end
					end
				end
				ST_ADD_D: begin
					start_q <= (quot == d_q);
					if (quot != d_q) begin
						state_q <= ST_ADD_Q;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_ADD_Q: begin
					start_q <= 1'b1;
					state_q <= ST_DIV;
				end
				ST_FIN: begin
					start_q <= 1'b0;
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					start_q <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					v_q   <= n;
					d_q   <= W'(1);
					acc_q <= '0;
				end
			end
			ST_DIV: begin
				if (div_done && !(d_q > quot) && (rem != '0)) begin
					d_q <= d_q + 1'b1;
				end
			end
			ST_ADD_D: begin
				acc_q <= acc_q + d_wide[SUM_BITS-1:0];
				if (quot == d_q) begin
					d_q <= d_q + 1'b1;
				end
			end
			ST_ADD_Q: begin
				acc_q <= acc_q + q_wide[SUM_BITS-1:0];
				d_q   <= d_q + 1'b1;
			end
			ST_FIN: begin
				if (out_free) begin
					out_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign divisor_sum = out_q;

endmodule

>>> tb/tb_divisor_sum_trial_division_core.sv
// Testbench for the divisor sum core: directed, back-pressure and random requests, scoreboarded.
module tb_divisor_sum_trial_division_core;
	import dsum_pkg::*;

	localparam int VALUE_BITS = 31;
	localparam int LONG_HOLD  = 4000;
	localparam int DRAIN_WAIT = 500;
	localparam int RANDOM_REQUESTS = 74;

	typedef enum int {
		RX_OPEN,
		RX_CHOPPY,
		RX_TIGHT
	} rx_mode_t;

	class divisor_sum_board;
		logic [SUM_BITS-1:0] pending_sums[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function longint unsigned divisor_total(longint unsigned value);
			longint unsigned acc;
			longint unsigned d;
			acc = 0;
			for (d = 1; d <= value / d; d++) begin
				if (value % d == 0) begin
					acc += d;
					if (value / d != d) acc += value / d;
				end
			end
			return acc;
		endfunction

		function void note_request(logic [VALUE_BITS-1:0] value);
			longint unsigned total;
			logic [SUM_BITS-1:0] trimmed;
			total = divisor_total(64'(value));
			trimmed = total[SUM_BITS-1:0];
			pending_sums.insert(pending_sums.size(), trimmed);
		endfunction

		function void check_sum(logic [SUM_BITS-1:0] actual);
			logic [SUM_BITS-1:0] wanted;
			if (pending_sums.size() == 0) begin
				$error("divisor_sum: no request pending, got %0d", actual);
				errors++;
			end else begin
				wanted = pending_sums.pop_front();
				if (actual !== wanted) begin
					$error("divisor_sum: expected %0d, got %0d", wanted, actual);
					errors++;
				end
			end
		endfunction

		function int pending_count();
			return pending_sums.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [VALUE_BITS-1:0] n;
	logic                  out_valid;
	logic                  out_ready;
	logic [SUM_BITS-1:0]   divisor_sum;
	logic                  hold_req = 1'b0;

	divisor_sum_board board = new();

	divisor_sum_trial_division_core #(
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.n(n),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.divisor_sum(divisor_sum)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_request(input logic [VALUE_BITS-1:0] value);
		in_valid <= 1'b1;
		n <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_request(value);
	endtask

	task automatic idle_for(input int cycles);
		logic [VALUE_BITS-1:0] junk;
		if (cycles > 0) begin
			junk = VALUE_BITS'($urandom);
			in_valid <= 1'b0;
			n <= junk;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending_count() != 0) @(posedge clk);
	endtask

	task automatic directed_requests();
		int unsigned picks[$];
		picks = '{0, 1, 2, 3, 4, 6, 12, 16, 25, 36, 97, 100, 120, 720, 1024, 4095,
			65535, 65536, 999983, 2147483647};
		foreach (picks[i]) begin
			send_request(VALUE_BITS'(picks[i]));
			idle_for($urandom_range(0, 5));
		end
	endtask

	// stall the output while requests keep coming so the core backs up
	task automatic backpressure_requests();
		hold_req = 1'b1;
		for (int k = 0; k < 6; k++) send_request(VALUE_BITS'($urandom_range(1, 60)));
	endtask

	task automatic random_requests(input int count);
		int sent;
		int burst;
		int pick;
		logic [VALUE_BITS-1:0] value;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 6);
			for (int k = 0; k < burst && sent < count; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 80) value = VALUE_BITS'($urandom_range(0, 4095));
				else if (pick < 95) value = VALUE_BITS'($urandom_range(0, 65535));
				else value = VALUE_BITS'($urandom_range(0, 1048575));
				send_request(value);
				sent++;
			end
			idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300));
		end
	endtask

	initial begin
		rx_mode_t mode;
		int mode_left;
		bit held;
		mode = RX_OPEN;
		mode_left = 0;
		held = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) board.check_sum(divisor_sum);
			if (hold_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(5, 80);
				end
				mode_left--;
				case (mode)
					RX_OPEN: begin
						out_ready <= 1'b1;
					end
					RX_CHOPPY: begin
						out_ready <= ($urandom_range(0, 1) == 1);
					end
					default: begin
						out_ready <= ($urandom_range(0, 7) == 0);
					end
				endcase
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		n <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_requests();
		wait_drained();
		backpressure_requests();
		wait_drained();
		random_requests(RANDOM_REQUESTS);
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (board.errors == 0 && board.pending_count() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#200000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sim.f
src/dsum_pkg.sv
src/dsum_divider.sv
src/divisor_sum_trial_division_core.sv
tb/tb_divisor_sum_trial_division_core.sv
